// ----- src/npds_pkg.sv -----
// Shared types, widths and constants for the nearest point distance search.
// Used by the core, the root/divide unit and the port checker. No dependencies.
package npds_pkg;

  localparam int COORD_BITS = 24;
  localparam int MAG_W      = COORD_BITS + 1;        // |a - b| needs one more bit
  localparam int PROD_W     = 2 * MAG_W;
  localparam int SQ_W       = 52;                    // squared distance, saturating
  localparam int WIDE_W     = (PROD_W > SQ_W) ? PROD_W : SQ_W;
  localparam int ACC_W      = SQ_W + 1;              // working width of the unit
  localparam int ROOT_W     = SQ_W / 2 + 1;
  localparam int ROOT_ITER  = SQ_W / 2;
  localparam int FRAC_DIR   = 14;
  localparam int NUM_W      = MAG_W + FRAC_DIR + 1;
  localparam int ITER_MAX   = (NUM_W > ROOT_ITER) ? NUM_W : ROOT_ITER;
  localparam int ITER_W     = $clog2(ITER_MAX + 1);
  localparam int DIST_W     = 25;
  localparam int DIR_W      = 16;
  localparam int DIR_UNIT   = 1 << FRAC_DIR;
  localparam int CFG_IDX_W  = 2;

  localparam logic [SQ_W-1:0]   SQ_INF   = {SQ_W{1'b1}};
  localparam logic [SQ_W-1:0]   SQ_SAT   = {{(SQ_W-1){1'b1}}, 1'b0};
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [DIR_W-1:0]  UNIT_Q14 = DIR_W'(DIR_UNIT);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUERY_X = 2'd0,
    REG_QUERY_Y = 2'd1,
    REG_QUERY_Z = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_ROOT = 1'b0,
    OP_DIV  = 1'b1
  } unit_op_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    logic   last_point;
  } point_t;

  typedef struct packed {
    logic [DIST_W-1:0]       min_distance;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    coord_t                  nearest_x;
    coord_t                  nearest_y;
    coord_t                  nearest_z;
  } result_t;

  typedef struct packed {
    logic              start;
    unit_op_t          op;
    logic [SQ_W-1:0]   rad;
    logic [NUM_W-1:0]  num;
    logic [ROOT_W-1:0] den;
  } unit_cmd_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] res;
  } unit_sts_t;

endpackage

// ----- src/npds_root_div.sv -----
// Iterative unit: rounded square root (two bits a step) or rounded-up-front
// restoring division (one bit a step), sharing one subtract/compare. Uses npds_pkg.
module npds_root_div (
  input  logic               clk,
  input  logic               rst,
  input  npds_pkg::unit_cmd_t cmd,
  output npds_pkg::unit_sts_t sts
);
  import npds_pkg::*;

  logic              busy;
  logic              done;
  unit_op_t          op;
  logic [ITER_W-1:0] cnt;
  logic [ACC_W-1:0]  n;      // radicand remainder / division remainder
  logic [ACC_W-1:0]  r;      // root / quotient
  logic [ACC_W-1:0]  b;      // root bit / numerator shift
  logic [ROOT_W-1:0] den;
  logic [ACC_W-1:0]  res;

  logic [ACC_W-1:0]  cmp_a;
  logic [ACC_W-1:0]  cmp_b;
  logic [ACC_W:0]    diff;
  logic              ge;

  always_comb begin
    if (op == OP_ROOT) begin
      cmp_a = n;
      cmp_b = r + b;
    end else begin
      cmp_a = {n[ACC_W-2:0], b[NUM_W-1]};
      cmp_b = ACC_W'(den);
    end
    diff = {1'b0, cmp_a} - {1'b0, cmp_b};
    ge   = ~diff[ACC_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op   <= OP_ROOT;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (!busy && cmd.start) begin
        busy <= 1'b1;
        op   <= cmd.op;
        cnt  <= (cmd.op == OP_ROOT) ? ITER_W'(ROOT_ITER) : ITER_W'(NUM_W);
      end else if (busy) begin
        if (cnt != '0) begin
          cnt <= cnt - 1'b1;
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && cmd.start) begin
      r   <= '0;
      den <= cmd.den;
      if (cmd.op == OP_ROOT) begin
        n <= ACC_W'(cmd.rad);
        b <= ACC_W'(1) << (SQ_W - 2);
      end else begin
        n <= '0;
        b <= ACC_W'(cmd.num);
      end
    end else if (busy) begin
      if (cnt != '0) begin
        if (op == OP_ROOT) begin
          if (ge) begin
            n <= diff[ACC_W-1:0];
            r <= (r >> 1) + b;
          end else begin
            r <= r >> 1;
          end
          b <= b >> 2;
        end else begin
          n <= ge ? diff[ACC_W-1:0] : cmp_a;
          r <= {r[ACC_W-2:0], ge};
          b <= b << 1;
        end
      end else begin
        // root rounds to nearest, ties up
        res <= (op == OP_ROOT && n > r) ? r + 1'b1 : r;
      end
    end
  end

  assign sts.done = done;
  assign sts.res  = res;

endmodule

// ----- src/nearest_point_distance_search_core.sv -----
// Top level of the nearest point distance search: sequencer, shared squarer
// and search state. Uses npds_pkg and npds_root_div.
//
// Use: write query_x/y/z through cfg_write/cfg_index/cfg_data (index 0..2,
// taken at once, no read-back), then stream the cloud's points on the in_*
// channel, the final one with last_point set. Each point is a valid/ready
// beat; nothing comes out for a point that is not last.
// Per point the block squares the three differences one axis a cycle on a
// single multiplier and then compares; in_ready stays low until the compare
// is done, so the next point waits for the whole pass.
// On the last point two square roots (26 steps each) and, unless the norm is
// zero, three divisions (NUM_W = COORD_BITS + 16 steps each) run on the
// shared root/divide unit before the result beat is offered on out_*.
// The result sits in an output register; a new cloud may start while it
// waits. If the receiver stalls past the next last point, the block holds
// that next result and stays busy until the register frees.
// Reset (synchronous, rst high) zeroes the query, empties the search and
// drops out_valid.
module nearest_point_distance_search_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  npds_pkg::point_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output npds_pkg::result_t               out_data,
  input  logic                            cfg_write,
  input  logic [npds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [npds_pkg::COORD_BITS-1:0] cfg_data
);
  import npds_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_SQ        = 8'b0000_0010,
    S_CMP       = 8'b0000_0100,
    S_ROOT_GO   = 8'b0000_1000,
    S_ROOT_WAIT = 8'b0001_0000,
    S_DIV_GO    = 8'b0010_0000,
    S_DIV_WAIT  = 8'b0100_0000,
    S_EMIT      = 8'b1000_0000
  } state_t;

  state_t state;
  logic   phase;       // 0: point search, 1: direction of the nearest point
  logic [1:0] cnt;

  coord_t query_x, query_y, query_z;
  coord_t pt_x, pt_y, pt_z;
  logic   pt_last;
  logic [SQ_W-1:0] best_dist_sq;
  coord_t best_x, best_y, best_z;

  logic [SQ_W-1:0]   acc;
  logic [SQ_W-1:0]   prod;
  logic [MAG_W-1:0]  mag_r [3];
  logic              neg_r [3];
  logic [DIST_W-1:0] min_dist;
  logic [ROOT_W-1:0] nrm;
  logic [DIR_W-1:0]  dir_r [3];

  unit_cmd_t ucmd;
  unit_sts_t usts;

  coord_t           sel_a, sel_b;
  logic [MAG_W-1:0] diff;
  logic             neg;
  logic [MAG_W-1:0] mag;
  logic [PROD_W-1:0] sq_raw;
  logic [WIDE_W-1:0] sq_wide;
  logic [SQ_W-1:0]   sq_sat;
  logic [SQ_W:0]     sum;
  logic [SQ_W-1:0]   acc_next;
  logic [ROOT_W-1:0] root;
  logic [NUM_W-1:0]  quot;
  logic [DIR_W-1:0]  qclamp;

  npds_root_div u_root_div (
    .clk (clk),
    .rst (rst),
    .cmd (ucmd),
    .sts (usts)
  );

  // one axis per cycle through the shared squarer
  always_comb begin
    unique case (cnt)
      2'd0:    begin sel_a = phase ? best_x : pt_x; sel_b = query_x; end
      2'd1:    begin sel_a = phase ? best_y : pt_y; sel_b = query_y; end
      default: begin sel_a = phase ? best_z : pt_z; sel_b = query_z; end
    endcase
    diff     = {sel_a[COORD_BITS-1], sel_a} - {sel_b[COORD_BITS-1], sel_b};
    neg      = diff[MAG_W-1];
    mag      = neg ? (~diff + 1'b1) : diff;
    sq_raw   = mag * mag;
    sq_wide  = WIDE_W'(sq_raw);
    sq_sat   = (sq_wide > WIDE_W'(SQ_SAT)) ? SQ_SAT : sq_wide[SQ_W-1:0];
    sum      = {1'b0, acc} + {1'b0, prod};
    acc_next = (sum > {1'b0, SQ_SAT}) ? SQ_SAT : sum[SQ_W-1:0];
  end

  always_comb begin
    root   = usts.res[ROOT_W-1:0];
    quot   = usts.res[NUM_W-1:0];
    qclamp = (quot > NUM_W'(DIR_UNIT)) ? UNIT_Q14 : quot[DIR_W-1:0];
  end

  always_comb begin
    ucmd.start = (state == S_ROOT_GO) || (state == S_DIV_GO && nrm != '0);
    ucmd.op    = (state == S_DIV_GO) ? OP_DIV : OP_ROOT;
    ucmd.rad   = phase ? acc : best_dist_sq;
    ucmd.num   = NUM_W'({mag_r[cnt], {FRAC_DIR{1'b0}}}) + NUM_W'(nrm[ROOT_W-1:1]);
    ucmd.den   = nrm;
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      query_x <= '0;
      query_y <= '0;
      query_z <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_QUERY_X: query_x <= cfg_data;
        REG_QUERY_Y: query_y <= cfg_data;
        REG_QUERY_Z: query_z <= cfg_data;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= 1'b0;
      cnt          <= '0;
      out_valid    <= 1'b0;
      best_dist_sq <= SQ_INF;
      best_x       <= '0;
      best_y       <= '0;
      best_z       <= '0;
    end else begin
      if (state == S_EMIT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            phase <= 1'b0;
            cnt   <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          cnt <= cnt + 1'b1;
          if (cnt == 2'd3) begin
            state <= phase ? S_ROOT_GO : S_CMP;
          end
        end
        S_CMP: begin
          if (acc < best_dist_sq) begin
            best_dist_sq <= acc;
            best_x       <= pt_x;
            best_y       <= pt_y;
            best_z       <= pt_z;
          end
          state <= pt_last ? S_ROOT_GO : S_IDLE;
        end
        S_ROOT_GO: begin
          state <= S_ROOT_WAIT;
        end
        S_ROOT_WAIT: begin
          if (usts.done) begin
            cnt <= '0;
            if (!phase) begin
              phase <= 1'b1;
              state <= S_SQ;
            end else begin
              state <= S_DIV_GO;
            end
          end
        end
        S_DIV_GO: begin
          // a zero norm means the nearest point is the query: no direction
          state <= (nrm == '0) ? S_EMIT : S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (usts.done) begin
            cnt   <= cnt + 1'b1;
            state <= (cnt == 2'd2) ? S_EMIT : S_DIV_GO;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            best_dist_sq <= SQ_INF;
            best_x       <= '0;
            best_y       <= '0;
            best_z       <= '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      pt_x    <= in_data.point_x;
      pt_y    <= in_data.point_y;
      pt_z    <= in_data.point_z;
      pt_last <= in_data.last_point;
      acc     <= '0;
    end
    if (state == S_ROOT_WAIT && usts.done && !phase) begin
      acc <= '0;
    end
    if (state == S_SQ) begin
      if (cnt != 2'd3) begin
        prod       <= sq_sat;
        mag_r[cnt] <= mag;
        neg_r[cnt] <= neg;
      end
      if (cnt != 2'd0) begin
        acc <= acc_next;
      end
    end
    if (state == S_ROOT_WAIT && usts.done) begin
      if (!phase) begin
        min_dist <= (root > ROOT_W'(DIST_MAX)) ? DIST_MAX : root[DIST_W-1:0];
      end else begin
        nrm <= root;
      end
    end
    if (state == S_DIV_GO && nrm == '0) begin
      dir_r[0] <= '0;
      dir_r[1] <= '0;
      dir_r[2] <= '0;
    end
    if (state == S_DIV_WAIT && usts.done) begin
      dir_r[cnt] <= neg_r[cnt] ? (~qclamp + 1'b1) : qclamp;
    end
    if (state == S_EMIT && (!out_valid || out_ready)) begin
      out_data.min_distance <= min_dist;
      out_data.dir_x        <= dir_r[0];
      out_data.dir_y        <= dir_r[1];
      out_data.dir_z        <= dir_r[2];
      out_data.nearest_x    <= best_x;
      out_data.nearest_y    <= best_y;
      out_data.nearest_z    <= best_z;
    end
  end

endmodule

// ----- src/npds_checker.sv -----
// Port-level checks for the nearest point distance search core, bound to it.
// Uses npds_pkg.
module npds_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input npds_pkg::point_t                in_data,
  input logic                            out_valid,
  input logic                            out_ready,
  input npds_pkg::result_t               out_data
);
  import npds_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // a point keeps the block busy for the squaring pass
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready straight after a beat");

  // a point that is not last never yields a result
  a_no_result_mid_cloud: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_data.last_point && !out_valid |=> !out_valid)
    else $error("result after a point that is not last");

  // direction components stay within one unit
  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      out_data.dir_x >= -DIR_UNIT && out_data.dir_x <= DIR_UNIT &&
      out_data.dir_y >= -DIR_UNIT && out_data.dir_y <= DIR_UNIT &&
      out_data.dir_z >= -DIR_UNIT && out_data.dir_z <= DIR_UNIT)
    else $error("direction component out of range");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind nearest_point_distance_search_core npds_checker u_npds_checker (.*);

// ----- tb/tb_nearest_point_distance_search_core.sv -----
// Testbench for nearest_point_distance_search_core: directed and random point
// clouds, each result beat checked against a behavioural model of the search.
// Depends on npds_pkg and the core RTL.
module tb_nearest_point_distance_search_core;
  timeunit 1ns;
  timeprecision 1ps;

  import npds_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 12;
  localparam int DRAIN_CYCLES  = 300;   // two roots and three divides, with margin
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_POINTS = 600;
  localparam int PHASE_POINTS  = 100;
  localparam int HOLD_CYCLES   = 3000;

  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  point_t                in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  result_t               out_data;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [COORD_BITS-1:0] cfg_data  = '0;

  nearest_point_distance_search_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // search model state
  coord_t          query_x = '0, query_y = '0, query_z = '0;
  logic [SQ_W-1:0] best_sq = SQ_INF;
  coord_t          best_x = '0, best_y = '0, best_z = '0;
  result_t         pending_nearest [$];

  int  mismatches      = 0;
  int  points_sent     = 0;
  int  clouds_sent     = 0;
  int  results_checked = 0;
  bit  steady          = 1'b0;

  // receiver hold-off requests; the receiver does its own counting
  int  hold_req_len  = 0;
  int  hold_req_id   = 0;
  int  hold_seen_id  = 0;
  int  hold_left     = 0;
  int  ready_wait    = 0;

  initial begin
    forever #(CLK_PERIOD/2) clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic longint unsigned abs_of(input longint d);
    return (d < 0) ? longint'(-d) : longint'(d);
  endfunction

  function automatic longint unsigned sq_capped(input longint unsigned m);
    longint unsigned s;
    s = m * m;
    return (s > SQ_SAT) ? longint'(SQ_SAT) : s;
  endfunction

  function automatic longint unsigned dist_sq3(input longint dx, dy, dz);
    longint unsigned s;
    s = sq_capped(abs_of(dx)) + sq_capped(abs_of(dy)) + sq_capped(abs_of(dz));
    return (s > SQ_SAT) ? longint'(SQ_SAT) : s;
  endfunction

  // integer square root, rounded to nearest with ties up
  function automatic longint unsigned root_nearest(input longint unsigned n);
    longint unsigned r, bit_v;
    r     = 0;
    bit_v = 64'h1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= r + bit_v) begin
        n = n - (r + bit_v);
        r = (r >> 1) + bit_v;
      end else begin
        r >>= 1;
      end
      bit_v >>= 2;
    end
    if (n > r) r++;
    return r;
  endfunction

  function automatic logic signed [DIR_W-1:0] unit_comp(input longint d,
                                                        input longint unsigned nrm);
    longint unsigned q;
    q = 0;
    if (nrm != 0) begin
      q = (abs_of(d) * DIR_UNIT + nrm / 2) / nrm;
      if (q > DIR_UNIT) q = DIR_UNIT;
    end
    return (d < 0) ? -DIR_W'(q) : DIR_W'(q);
  endfunction

  task automatic search_point(input point_t p);
    longint unsigned sq, nrm, dist_v;
    longint          dx, dy, dz;
    result_t         r;
    sq = dist_sq3(longint'(p.point_x) - longint'(query_x),
                  longint'(p.point_y) - longint'(query_y),
                  longint'(p.point_z) - longint'(query_z));
    // strictly smaller only, so the earliest of equal points stays
    if (sq < best_sq) begin
      best_sq = sq[SQ_W-1:0];
      best_x  = p.point_x;
      best_y  = p.point_y;
      best_z  = p.point_z;
    end
    if (p.last_point) begin
      dist_v         = root_nearest(best_sq);
      r.min_distance = (dist_v > DIST_MAX) ? DIST_MAX : dist_v[DIST_W-1:0];
      dx  = longint'(best_x) - longint'(query_x);
      dy  = longint'(best_y) - longint'(query_y);
      dz  = longint'(best_z) - longint'(query_z);
      nrm = root_nearest(dist_sq3(dx, dy, dz));
      r.dir_x     = unit_comp(dx, nrm);
      r.dir_y     = unit_comp(dy, nrm);
      r.dir_z     = unit_comp(dz, nrm);
      r.nearest_x = best_x;
      r.nearest_y = best_y;
      r.nearest_z = best_z;
      pending_nearest = {pending_nearest, r};
      best_sq = SQ_INF;
      best_x  = '0;
      best_y  = '0;
      best_z  = '0;
      clouds_sent++;
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input logic signed [31:0] want, got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (pending_nearest.size() == 0) begin
      $display("%0t: unexpected result beat: expected none, actual %h", $time, got);
      mismatches++;
    end else begin
      want = pending_nearest.pop_front();
      check_field("min_distance", want.min_distance, got.min_distance);
      check_field("dir_x", want.dir_x, got.dir_x);
      check_field("dir_y", want.dir_y, got.dir_y);
      check_field("dir_z", want.dir_z, got.dir_z);
      check_field("nearest_x", want.nearest_x, got.nearest_x);
      check_field("nearest_y", want.nearest_y, got.nearest_y);
      check_field("nearest_z", want.nearest_z, got.nearest_z);
      results_checked++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        check_result(out_data);
        ready_wait = steady ? 0 : $urandom_range(0, 4);
      end
      if (hold_req_id != hold_seen_id) begin
        hold_seen_id = hold_req_id;
        hold_left    = hold_req_len;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (ready_wait != 0) begin
        ready_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned n;
    n = 0;
    while (n < CYCLE_LIMIT) begin
      @(posedge clk);
      n++;
    end
    $display("tb_nearest_point_distance_search_core failed");
    $finish;
  end

  // ---------------------------------------------------------------- driving

  task automatic send_point(input point_t p);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    search_point(p);
    points_sent++;
  endtask

  // three back-to-back register beats; write enable stays high throughout
  task automatic set_query(input coord_t x, y, z);
    cfg_write <= 1'b1;
    cfg_index <= REG_QUERY_X;
    cfg_data  <= x;
    @(posedge clk);
    cfg_index <= REG_QUERY_Y;
    cfg_data  <= y;
    @(posedge clk);
    cfg_index <= REG_QUERY_Z;
    cfg_data  <= z;
    @(posedge clk);
    cfg_write <= 1'b0;
    query_x = x;
    query_y = y;
    query_z = z;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_nearest.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic point_t pt(input coord_t x, y, z, input bit last);
    point_t p;
    p.point_x    = x;
    p.point_y    = y;
    p.point_z    = z;
    p.last_point = last;
    return p;
  endfunction

  function automatic coord_t near_coord(input coord_t centre);
    longint v;
    int     span;
    span = $urandom_range(0, 22);
    v = longint'(centre) + longint'($urandom_range(0, 2 << span)) - (longint'(1) << span);
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return coord_t'(v);
  endfunction

  function automatic coord_t extreme_coord();
    case ($urandom_range(0, 3))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic point_t random_point(input point_t prev, input bit last);
    point_t p;
    int     pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)
      p = pt(near_coord(query_x), near_coord(query_y), near_coord(query_z), last);
    else if (pick < 70)
      p = pt(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), last);
    else if (pick < 80)
      p = prev;                        // repeat for a tie
    else if (pick < 88)
      p = pt(query_x, query_y, query_z, last);
    else
      p = pt(extreme_coord(), extreme_coord(), extreme_coord(), last);
    p.last_point = last;
    return p;
  endfunction

  task automatic send_random_cloud(input int n);
    point_t p;
    p = pt(near_coord(query_x), near_coord(query_y), near_coord(query_z), 1'b0);
    for (int i = 0; i < n; i++) begin
      p = random_point(p, i == n - 1);
      send_point(p);
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_zero_distance();
    send_point(pt('0, '0, '0, 1'b1));
    send_point(pt(24'sd4096, '0, '0, 1'b0));
    send_point(pt('0, '0, '0, 1'b1));
    settle();
  endtask

  task automatic test_tie_first_wins();
    set_query(24'sd1000, -24'sd2000, 24'sd3000);
    send_point(pt(24'sd5096, -24'sd2000, 24'sd3000, 1'b0));
    send_point(pt(-24'sd3096, -24'sd2000, 24'sd3000, 1'b0));
    send_point(pt(24'sd1000, 24'sd2096, 24'sd3000, 1'b1));
    // later, strictly closer point replaces the first
    send_point(pt(24'sd9000, '0, '0, 1'b0));
    send_point(pt(24'sd1001, -24'sd1999, 24'sd2999, 1'b0));
    send_point(pt(24'sd1001, -24'sd1999, 24'sd3001, 1'b1));
    settle();
  endtask

  task automatic test_extremes();
    set_query(COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(pt(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
    settle();
    set_query(COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(pt(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1));
    settle();
    set_query(COORD_MIN, COORD_MAX, '0);
    send_point(pt(COORD_MAX, COORD_MIN, '0, 1'b0));
    send_point(pt('0, '0, COORD_MAX, 1'b1));
    settle();
  endtask

  task automatic test_axis_directions();
    set_query('0, '0, '0);
    send_point(pt(24'sd4096, '0, '0, 1'b1));
    send_point(pt(-24'sd4096, '0, '0, 1'b1));
    send_point(pt('0, 24'sd4096, '0, 1'b1));
    send_point(pt('0, -24'sd4096, '0, 1'b1));
    send_point(pt('0, '0, 24'sd4096, 1'b1));
    send_point(pt('0, '0, -24'sd4096, 1'b1));
    settle();
  endtask

  task automatic test_random_clouds();
    int budget;
    budget = 0;
    while (budget < RANDOM_POINTS) begin
      case ($urandom_range(0, 3))
        0:       set_query('0, '0, '0);
        1:       set_query(extreme_coord(), extreme_coord(), extreme_coord());
        2:       set_query(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
        default: set_query(near_coord('0), near_coord('0), near_coord('0));
      endcase
      for (int sent = 0; sent < PHASE_POINTS; ) begin
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        send_random_cloud(n);
        sent   += n;
        budget += n;
      end
      settle();
    end
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    for (int i = 0; i < 8; i++) send_random_cloud($urandom_range(1, 6));
    settle();
    steady = 1'b0;
  endtask

  task automatic test_output_stall();
    hold_req_len = HOLD_CYCLES;
    hold_req_id++;
    // more clouds than the block can hold; the input has to stall
    for (int i = 0; i < 4; i++) send_random_cloud(3);
    settle();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_zero_distance();
    test_tie_first_wins();
    test_extremes();
    test_axis_directions();
    test_random_clouds();
    test_back_to_back();
    test_output_stall();
    settle();
    $display("%0d points in %0d clouds sent, %0d result beats checked",
             points_sent, clouds_sent, results_checked);
    $display("covered zero distance, ties, coordinate extremes, axis directions, "
             , "random clouds, back-to-back beats and a long output stall");
    if (mismatches == 0) begin
      $display("tb_nearest_point_distance_search_core passed");
    end else begin
      $display("tb_nearest_point_distance_search_core failed");
    end
    $finish;
  end

endmodule
